// File: src/tlbpt_pkg.sv
`default_nettype none
package tlbpt_pkg;

  localparam int unsigned VA_W   = 16;
  localparam int unsigned PAGE_W = 8;
  localparam int unsigned OFF_W  = 8;
  localparam int unsigned CNT_W  = 32;

  // One classified request handed from the front end to the back end.
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  offset;
    logic              hit;
    logic [PAGE_W-1:0] frame;
  } tlbpt_req_t;

endpackage
`default_nettype wire

// File: src/tlbpt_front.sv
`default_nettype none
// TLB lookup and refill. Accepts a transfer, classifies it as hit or miss and
// pushes it into the request queue. The back end writes refills and drops.
module tlbpt_front #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [tlbpt_pkg::VA_W-1:0] va,
  output tlbpt_pkg::tlbpt_req_t           req,
  input  wire logic                       fill_en,
  input  wire logic [tlbpt_pkg::PAGE_W-1:0] fill_page,
  input  wire logic [tlbpt_pkg::PAGE_W-1:0] fill_frame,
  input  wire logic                       drop_en,
  input  wire logic [tlbpt_pkg::PAGE_W-1:0] drop_page
);
  import tlbpt_pkg::*;

  localparam int unsigned TI_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  // Rounded-up reciprocal; exact for every 8-bit page number.
  localparam int unsigned PG_RECIP = (65536 + PAGE_COUNT - 1) / PAGE_COUNT;

  logic [TLB_ENTRIES-1:0] valid_r;
  logic [TLB_ENTRIES-1:0] valid_nxt;
  logic [PAGE_W-1:0]      page_r  [TLB_ENTRIES];
  logic [PAGE_W-1:0]      frame_r [TLB_ENTRIES];
  logic [TI_W-1:0]        ptr_r;
  logic [PAGE_W-1:0]      pg;
  logic [31:0]            pg_prod;
  logic [PAGE_W-1:0]      pg_quo;
  logic                   hit;
  logic [PAGE_W-1:0]      fr;

  always_comb begin
    pg_prod = 32'(va[VA_W-1:OFF_W]) * PG_RECIP;
    pg_quo  = PAGE_W'(pg_prod >> 16);
    pg      = PAGE_W'(32'(va[VA_W-1:OFF_W]) - 32'(pg_quo) * PAGE_COUNT);
    hit = 1'b0;
    fr  = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && page_r[i] == pg) begin
        hit = 1'b1;
        fr  = frame_r[i];
      end
    end
    req.page   = pg;
    req.offset = va[OFF_W-1:0];
    req.hit    = hit;
    req.frame  = fr;
  end

  // Drops clear first; a refill into the same slot then marks it valid.
  always_comb begin
    valid_nxt = valid_r;
    if (drop_en) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (valid_r[i] && page_r[i] == drop_page) valid_nxt[i] = 1'b0;
      end
    end
    if (fill_en) valid_nxt[ptr_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ptr_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (fill_en) begin
        ptr_r <= (32'(ptr_r) == TLB_ENTRIES - 1) ? '0 : ptr_r + 1'b1;
      end
    end
    if (fill_en) begin
      page_r[ptr_r]  <= fill_page;
      frame_r[ptr_r] <= fill_frame;
    end
  end
endmodule
`default_nettype wire

// File: src/tlbpt_back.sv
`default_nettype none
// Page table walk and frame assignment. Holds page table and frame owner
// memories and the counters; produces one result per request.
module tlbpt_back #(
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned FRAME_COUNT = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  req_valid,
  input  tlbpt_pkg::tlbpt_req_t      req,
  output logic                       req_pop,
  output logic                       fill_en,
  output logic [tlbpt_pkg::PAGE_W-1:0] fill_page,
  output logic [tlbpt_pkg::PAGE_W-1:0] fill_frame,
  output logic                       drop_en,
  output logic [tlbpt_pkg::PAGE_W-1:0] drop_page,
  output logic                       res_valid,
  output logic [tlbpt_pkg::VA_W-1:0] res_pa,
  output logic                       res_hit,
  output logic                       res_fault,
  output logic                       res_ev,
  output logic [tlbpt_pkg::PAGE_W-1:0] res_ev_page,
  output logic [tlbpt_pkg::CNT_W-1:0]  res_acc,
  output logic [tlbpt_pkg::CNT_W-1:0]  res_flt,
  output logic [tlbpt_pkg::CNT_W-1:0]  res_mis
);
  import tlbpt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_OWNER, S_CHECK, S_DONE} state_t;

  localparam int unsigned PI_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned FI_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  state_t state_r;
  tlbpt_req_t cur_r;
  logic [PAGE_COUNT-1:0] present_r;
  logic [PAGE_W-1:0] page_frame_mem [PAGE_COUNT];
  logic [PAGE_W-1:0] owner_mem [FRAME_COUNT];
  logic [PAGE_W-1:0] pf_rd_r, own_rd_r, pf_own_rd_r;
  logic [FI_W-1:0] fptr_r;
  logic filled_r;
  logic [CNT_W-1:0] acc_r, flt_r, mis_r;
  logic [PI_W-1:0] owner_idx;

  // Owner entries only ever hold page numbers already in range.
  assign owner_idx = PI_W'(own_rd_r);
  assign req_pop = (state_r == S_IDLE) && req_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      present_r <= '0;
      fptr_r    <= '0;
      filled_r  <= 1'b0;
      acc_r <= '0; flt_r <= '0; mis_r <= '0;
      fill_en <= 1'b0; drop_en <= 1'b0; res_valid <= 1'b0;
    end else begin
      fill_en <= 1'b0; drop_en <= 1'b0; res_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (req_valid) begin
          cur_r <= req;
          acc_r <= acc_r + 1'b1;
          if (req.hit) begin
            res_valid <= 1'b1;
            res_pa <= {req.frame, req.offset};
            res_hit <= 1'b1; res_fault <= 1'b0; res_ev <= 1'b0;
            res_ev_page <= '0;
            res_acc <= acc_r + 1'b1; res_flt <= flt_r; res_mis <= mis_r;
            state_r <= S_DONE;
          end else begin
            mis_r <= mis_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_OWNER; // page table and owner reads land
        S_OWNER: state_r <= S_CHECK; // owner's mapping read lands
        S_CHECK: begin
          res_valid <= 1'b1;
          res_hit <= 1'b0;
          res_acc <= acc_r; res_mis <= mis_r;
          res_ev <= 1'b0; res_ev_page <= '0;
          fill_en <= 1'b1;
          fill_page <= cur_r.page;
          if (present_r[PI_W'(cur_r.page)]) begin
            res_pa <= {pf_rd_r, cur_r.offset};
            fill_frame <= pf_rd_r;
            res_fault <= 1'b0; res_flt <= flt_r;
          end else begin
            res_fault <= 1'b1;
            flt_r <= flt_r + 1'b1; res_flt <= flt_r + 1'b1;
            res_pa <= {PAGE_W'(fptr_r), cur_r.offset};
            fill_frame <= PAGE_W'(fptr_r);
            if (filled_r && present_r[owner_idx] && pf_own_rd_r == PAGE_W'(fptr_r)) begin
              present_r[owner_idx] <= 1'b0;
              drop_en <= 1'b1; drop_page <= PAGE_W'(owner_idx);
              res_ev <= 1'b1; res_ev_page <= PAGE_W'(owner_idx);
            end
            present_r[PI_W'(cur_r.page)] <= 1'b1;
            if (32'(fptr_r) == FRAME_COUNT - 1) begin
              fptr_r <= '0; filled_r <= 1'b1;
            end else fptr_r <= fptr_r + 1'b1;
          end
          state_r <= S_DONE;
        end
        S_DONE: state_r <= S_IDLE; // lets the TLB refill settle
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Memories: registered reads, one write port each.
  always_ff @(posedge clk) begin
    pf_rd_r     <= page_frame_mem[PI_W'(cur_r.page)];
    own_rd_r    <= owner_mem[fptr_r];
    pf_own_rd_r <= page_frame_mem[owner_idx];
    if (state_r == S_CHECK && !present_r[PI_W'(cur_r.page)]) begin
      page_frame_mem[PI_W'(cur_r.page)] <= PAGE_W'(fptr_r);
      owner_mem[fptr_r] <= cur_r.page;
    end
  end
endmodule
`default_nettype wire

// File: src/tlb_page_table_translator.sv
`default_nettype none
// A TLB hit is queued, then answered from the back end's idle state; a miss
// passes its read, owner and check states too. No new transfer is taken
// until the last result is out, set by the back end's sequencer and registered
// page table reads. The receiver cannot stall; each result is shown for one
// cycle. A synchronous active-low reset clears TLB valid bits, page present
// bits, the frame pointer and all counters; no clearing pass is needed.
module tlb_page_table_translator #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned FRAME_COUNT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_virtual_address,
  output logic             out_valid,
  output logic [15:0]      out_physical_address,
  output logic             out_tlb_hit,
  output logic             out_page_fault,
  output logic             out_evict_valid,
  output logic [7:0]       out_evicted_page,
  output logic [31:0]      out_total_accesses,
  output logic [31:0]      out_total_faults,
  output logic [31:0]      out_total_tlb_misses
);
  import tlbpt_pkg::*;

  tlbpt_req_t front_req, q_r;
  logic q_valid_r, req_pop, fill_en, drop_en, take;
  logic [PAGE_W-1:0] fill_page, fill_frame, drop_page;
  logic inflight_r;

  // The front end classifies against the current TLB. Only one item is in
  // flight at a time, so the lookup never sees a refill still pending.
  assign busy = q_valid_r || inflight_r;
  assign take = start && !busy;

  tlbpt_front #(.TLB_ENTRIES(TLB_ENTRIES), .PAGE_COUNT(PAGE_COUNT)) u_front (
    .clk, .rst_n, .va(in_virtual_address), .req(front_req),
    .fill_en, .fill_page, .fill_frame, .drop_en, .drop_page
  );

  // One-entry queue between the classifier and the back end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r  <= 1'b0;
      inflight_r <= 1'b0;
    end else begin
      if (take) q_valid_r <= 1'b1;
      else if (req_pop) q_valid_r <= 1'b0;
      if (req_pop) inflight_r <= 1'b1;
      else if (out_valid) inflight_r <= 1'b0;
    end
    if (take) q_r <= front_req;
  end

  tlbpt_back #(.PAGE_COUNT(PAGE_COUNT), .FRAME_COUNT(FRAME_COUNT)) u_back (
    .clk, .rst_n, .req_valid(q_valid_r), .req(q_r), .req_pop,
    .fill_en, .fill_page, .fill_frame, .drop_en, .drop_page,
    .res_valid(out_valid), .res_pa(out_physical_address), .res_hit(out_tlb_hit),
    .res_fault(out_page_fault), .res_ev(out_evict_valid),
    .res_ev_page(out_evicted_page), .res_acc(out_total_accesses),
    .res_flt(out_total_faults), .res_mis(out_total_tlb_misses)
  );

  // An eviction only happens together with a page fault.
  a_ev_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evict_valid |-> out_page_fault) else $error("evict without fault");
  // A hit never faults.
  a_hit_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tlb_hit |-> !out_page_fault) else $error("hit with fault");
  // No new transfer is taken while an item is still queued.
  a_q_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid_r |-> busy) else $error("queue not guarded");
endmodule
`default_nettype wire
